[src/lfsd_pkg.sv]
package lfsd_pkg;

  localparam int unsigned NumServers = 16;
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned MaxResults = 17;

  localparam int unsigned SrvW = (NumServers > 1) ? $clog2(NumServers) : 1;
  localparam int unsigned QW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned ResW = $clog2(MaxResults + 1);

  localparam logic [1:0] ReqLoad   = 2'd0;
  localparam logic [1:0] ReqTask   = 2'd1;
  localparam logic [1:0] ReqIdle   = 2'd2;
  localparam logic [1:0] ReqUnused = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StDec,
    StEnq,
    StDrop,
    StScan,
    StHeadRd,
    StHeadWait,
    StEmit,
    StDone
  } state_e;

endpackage

[src/lfsd_ram.sv]
module lfsd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/lightest_free_server_dispatcher_top.sv]
// lightest free server dispatcher
// input channel (valid_i/ready_o) carries req_type_i, server_index_i, weight_i
// and duration_i. output channel (valid_o/ready_i) carries task_number_o,
// server_index_out_o, status_o and last_o; last_o marks the final result
// beat of a tick. loads and idle ticks with nothing to assign give no beat.
// one item at a time: ready_o is high only in the idle state.
// server weights and remaining times sit in flip-flops; the waiting queue
// (duration and task number) sits in two rams with registered reads.
// a load is taken in the idle state alone. a tick passes the accept state, a
// count-down state, an enqueue state (tasks only), a drop beat if the queue
// was full, then per assignment a server scan, head read, ram wait and output
// beat, and last a final scan and a done state.
// a stalled receiver (ready_i low) holds the result beat and the sequencer.
// reset (rst_ni low) frees all servers, zeroes weights and empties the queue;
// no clearing pass is needed.
module lightest_free_server_dispatcher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  server_index_i,
  input  logic [15:0] weight_i,
  input  logic [15:0] duration_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] task_number_o,
  output logic [3:0]  server_index_out_o,
  output logic        status_o,
  output logic        last_o
);

  localparam int unsigned NS = lfsd_pkg::NumServers;
  localparam int unsigned SW = lfsd_pkg::SrvW;
  localparam int unsigned QW = lfsd_pkg::QW;
  localparam int unsigned CW = lfsd_pkg::CntW;
  localparam int unsigned RW = lfsd_pkg::ResW;
  localparam int unsigned NT = 2 * NS - 1;

  lfsd_pkg::state_e state_q, state_d;

  logic [15:0]   weights_q [NS];
  logic [15:0]   remain_q  [NS];
  logic [QW-1:0] head_q;
  logic [CW-1:0] count_q;
  logic [31:0]   arrival_q;
  logic [RW-1:0] nres_q;
  logic          is_task_q;
  logic [15:0]   dur_q;
  logic [SW-1:0] pick_q;

  logic [31:0] num_out;
  logic [3:0]  srv_out;
  logic        st_out;
  logic        last_out;

  logic [15:0] rd_dur;
  logic [31:0] rd_num;
  logic        wr_en;
  logic [QW-1:0] wr_addr;

  // lightest free server: pairwise tree, leaves in server order, ties go left
  logic          t_ok [NT];
  logic [15:0]   t_w  [NT];
  logic [SW-1:0] t_ix [NT];
  logic          found;
  logic [SW-1:0] best;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      t_ok[NS-1+s] = (remain_q[s] == 16'd0);
      t_w[NS-1+s]  = weights_q[s];
      t_ix[NS-1+s] = SW'(s);
    end
    for (int k = NS - 2; k >= 0; k--) begin
      if (t_ok[2*k+1] && (!t_ok[2*k+2] || t_w[2*k+1] <= t_w[2*k+2])) begin
        t_ok[k] = 1'b1;
        t_w[k]  = t_w[2*k+1];
        t_ix[k] = t_ix[2*k+1];
      end else begin
        t_ok[k] = t_ok[2*k+2];
        t_w[k]  = t_w[2*k+2];
        t_ix[k] = t_ix[2*k+2];
      end
    end
  end

  assign found = t_ok[0];
  assign best  = t_ix[0];

  logic queue_full;
  logic can_assign;
  assign queue_full = (count_q == CW'(lfsd_pkg::QueueDepth));
  assign can_assign = (count_q != '0) && found && (nres_q < RW'(lfsd_pkg::MaxResults));

  assign wr_en   = (state_q == lfsd_pkg::StEnq) && !queue_full;
  assign wr_addr = QW'((CW+1)'(head_q) + (CW+1)'(count_q));

  lfsd_ram #(.Width(16), .Depth(lfsd_pkg::QueueDepth)) u_dur_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i ((dur_q == 16'd0) ? 16'd1 : dur_q),
    .raddr_i (head_q),
    .rdata_o (rd_dur)
  );

  lfsd_ram #(.Width(32), .Depth(lfsd_pkg::QueueDepth)) u_num_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (arrival_q),
    .raddr_i (head_q),
    .rdata_o (rd_num)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lfsd_pkg::StIdle: begin
        if (valid_i && (req_type_i inside {lfsd_pkg::ReqTask, lfsd_pkg::ReqIdle})) begin
          state_d = lfsd_pkg::StDec;
        end
      end
      lfsd_pkg::StDec:      state_d = is_task_q ? lfsd_pkg::StEnq : lfsd_pkg::StScan;
      lfsd_pkg::StEnq:      state_d = queue_full ? lfsd_pkg::StDrop : lfsd_pkg::StScan;
      lfsd_pkg::StDrop:     if (ready_i) state_d = lfsd_pkg::StScan;
      lfsd_pkg::StScan:     state_d = can_assign ? lfsd_pkg::StHeadRd : lfsd_pkg::StDone;
      lfsd_pkg::StHeadRd:   state_d = lfsd_pkg::StHeadWait;
      lfsd_pkg::StHeadWait: state_d = lfsd_pkg::StEmit;
      lfsd_pkg::StEmit:     if (ready_i) state_d = lfsd_pkg::StScan;
      lfsd_pkg::StDone:     state_d = lfsd_pkg::StIdle;
      default:              state_d = lfsd_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    ready_o = (state_q == lfsd_pkg::StIdle);
    valid_o = 1'b0;
    case (state_q)
      lfsd_pkg::StDrop, lfsd_pkg::StEmit: valid_o = 1'b1;
      default:                            valid_o = 1'b0;
    endcase
  end

  // a drop beat is last only if nothing is assigned after it; the scan state
  // is not changed by the drop, so it can be looked at ahead
  logic drop_last;
  assign drop_last = !can_assign;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lfsd_pkg::StIdle;
      head_q    <= '0;
      count_q   <= '0;
      arrival_q <= '0;
      nres_q    <= '0;
      is_task_q <= 1'b0;
      pick_q    <= '0;
      for (int s = 0; s < NS; s++) begin
        weights_q[s] <= '0;
        remain_q[s]  <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        lfsd_pkg::StIdle: begin
          nres_q <= '0;
          if (valid_i) begin
            is_task_q <= (req_type_i == lfsd_pkg::ReqTask);
            if (req_type_i == lfsd_pkg::ReqLoad && 32'(server_index_i) < 32'(NS)) begin
              weights_q[SW'(server_index_i)] <= weight_i;
            end
          end
        end
        lfsd_pkg::StDec: begin
          for (int s = 0; s < NS; s++) begin
            if (remain_q[s] != 16'd0) remain_q[s] <= remain_q[s] - 16'd1;
          end
        end
        lfsd_pkg::StEnq: begin
          arrival_q <= arrival_q + 32'd1;
          if (queue_full) begin
            nres_q <= RW'(1);
          end else begin
            count_q <= count_q + CW'(1);
          end
        end
        lfsd_pkg::StScan: begin
          pick_q <= best;
        end
        lfsd_pkg::StEmit: begin
          if (ready_i) begin
            remain_q[pick_q] <= rd_dur;
            head_q  <= head_q + QW'(1);
            count_q <= count_q - CW'(1);
            nres_q  <= nres_q + RW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // duration of the accepted beat, written to the queue in the enqueue state
  always_ff @(posedge clk_i) begin
    if (state_q == lfsd_pkg::StIdle && valid_i) begin
      dur_q <= duration_i;
    end
  end

  // head read issued in StHeadRd lands in StHeadWait; rams hold it until next
  // read since head_q does not move before the beat
  logic emit_last;
  logic free_after;
  logic [CW-1:0] cnt_after;
  always_comb begin
    free_after = 1'b0;
    for (int s = 0; s < NS; s++) begin
      if (remain_q[s] == 16'd0 && SW'(s) != pick_q) free_after = 1'b1;
    end
    cnt_after = count_q - CW'(1);
    emit_last = (cnt_after == '0) || !free_after ||
                (nres_q + RW'(1) >= RW'(lfsd_pkg::MaxResults));
  end

  assign num_out  = (state_q == lfsd_pkg::StDrop) ? (arrival_q - 32'd1) : rd_num;
  assign srv_out  = (state_q == lfsd_pkg::StDrop) ? 4'd0 : 4'(pick_q);
  assign st_out   = (state_q == lfsd_pkg::StDrop);
  assign last_out = (state_q == lfsd_pkg::StDrop) ? drop_last : emit_last;

  assign task_number_o      = num_out;
  assign server_index_out_o = srv_out;
  assign status_o           = st_out;
  assign last_o             = last_out;

endmodule

[dv/lightest_free_server_dispatcher_top_test.sv]
module lightest_free_server_dispatcher_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] task_num;
    logic [3:0]  srv;
    logic        dropped;
    logic        last;
  } dispatch_t;

  class dispatch_scoreboard;
    logic [15:0] weights[lfsd_pkg::NumServers];
    logic [15:0] busy_left[lfsd_pkg::NumServers];
    logic [15:0] fifo_dur[$];
    logic [31:0] fifo_num[$];
    logic [31:0] next_num;
    dispatch_t   pending[$];
    int          errors;

    function void clear();
      foreach (weights[s]) begin
        weights[s] = '0;
        busy_left[s] = '0;
      end
      fifo_dur.delete();
      fifo_num.delete();
      next_num = '0;
      pending.delete();
      errors = 0;
    endfunction

    function int lightest_free();
      int best;
      best = -1;
      for (int s = 0; s < lfsd_pkg::NumServers; s++) begin
        if (busy_left[s] != 0) continue;
        if (best < 0 || weights[s] < weights[best]) best = s;
      end
      return best;
    endfunction

    function void note_request(logic [1:0] req, logic [3:0] sidx, logic [15:0] w,
                               logic [15:0] dur);
      int n;
      int srv;
      dispatch_t d;
      n = 0;
      if (req == lfsd_pkg::ReqLoad) begin
        if (sidx < lfsd_pkg::NumServers) weights[sidx] = w;
        return;
      end
      if (req != lfsd_pkg::ReqTask && req != lfsd_pkg::ReqIdle) return;
      foreach (busy_left[s]) if (busy_left[s] != 0) busy_left[s]--;
      if (req == lfsd_pkg::ReqTask) begin
        if (fifo_dur.size() >= lfsd_pkg::QueueDepth) begin
          d = '{next_num, 4'd0, 1'b1, 1'b0};
          pending.insert(pending.size(), d);
          n++;
        end else begin
          fifo_dur.insert(fifo_dur.size(), dur == 0 ? 16'd1 : dur);
          fifo_num.insert(fifo_num.size(), next_num);
        end
        next_num++;
      end
      while (fifo_dur.size() > 0 && n < lfsd_pkg::MaxResults) begin
        srv = lightest_free();
        if (srv < 0) break;
        busy_left[srv] = fifo_dur.pop_front();
        d = '{fifo_num.pop_front(), srv[3:0], 1'b0, 1'b0};
        pending.insert(pending.size(), d);
        n++;
      end
      if (n > 0) pending[$].last = 1'b1;
    endfunction

    function void check_result(dispatch_t got);
      dispatch_t exp_d;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, got);
        errors++;
        return;
      end
      exp_d = pending.pop_front();
      if (got.task_num !== exp_d.task_num)
        $display("%0t: task_number exp %0d got %0d", $time, exp_d.task_num, got.task_num);
      if (got.srv !== exp_d.srv)
        $display("%0t: server exp %0d got %0d", $time, exp_d.srv, got.srv);
      if (got.dropped !== exp_d.dropped)
        $display("%0t: status exp %0b got %0b", $time, exp_d.dropped, got.dropped);
      if (got.last !== exp_d.last)
        $display("%0t: last exp %0b got %0b", $time, exp_d.last, got.last);
      if (got !== exp_d) errors++;
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        valid_i, ready_o, valid_o, ready_i;
  logic [1:0]  req_type_i;
  logic [3:0]  server_index_i, server_index_out_o;
  logic [15:0] weight_i, duration_i;
  logic [31:0] task_number_o;
  logic        status_o, last_o;

  dispatch_scoreboard sb;
  int  cycles;
  bit  long_stall;

  lightest_free_server_dispatcher_top i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: stall pattern, plus one long hold-off on request
  initial begin
    int hold;
    ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_stall) begin
        ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_stall = 1'b0;
      end
      hold = $urandom_range(0, 7);
      if (cycles % 1000 < 300) ready_i <= 1'b1;
      else ready_i <= (hold < 5);
    end
  end

  // sampled between edges, where valid_o and the payload have settled
  always @(negedge clk_i) begin
    if (rst_ni && valid_o && ready_i)
      sb.check_result('{task_number_o, server_index_out_o, status_o, last_o});
  end

  task automatic send_beat(logic [1:0] req, logic [3:0] sidx, logic [15:0] w,
                           logic [15:0] dur);
    bit rdy;
    valid_i <= 1'b1;
    req_type_i <= req;
    server_index_i <= sidx;
    weight_i <= w;
    duration_i <= dur;
    do begin
      @(negedge clk_i);
      rdy = ready_o;
      @(posedge clk_i);
    end while (!rdy);
    sb.note_request(req, sidx, w, dur);
  endtask

  task automatic pause_sender(int n);
    valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic random_beat(int heavy);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)
      send_beat(lfsd_pkg::ReqLoad, 4'($urandom()), 16'($urandom()), 16'($urandom()));
    else if (r < 12 + heavy)
      send_beat(lfsd_pkg::ReqTask, 4'($urandom()), 16'($urandom()),
                ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                16'($urandom_range(0, 12)));
    else if (r < 98)
      send_beat(lfsd_pkg::ReqIdle, 4'($urandom()), 16'($urandom()), 16'($urandom()));
    else
      send_beat(lfsd_pkg::ReqUnused, 4'($urandom()), 16'($urandom()), 16'($urandom()));
  endtask

  initial begin
    int burst;
    bit mid_done;
    sb = new();
    sb.clear();
    cycles = 0;
    long_stall = 1'b0;
    mid_done = 1'b0;
    valid_i = 1'b0;
    req_type_i = lfsd_pkg::ReqIdle;
    server_index_i = '0;
    weight_i = '0;
    duration_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: weights at extremes, ties, zero duration, long duration,
    // ignored req 3, then a run of tasks
    send_beat(lfsd_pkg::ReqLoad, 4'd15, 16'h0000, 16'hffff);
    send_beat(lfsd_pkg::ReqLoad, 4'd0, 16'hffff, 16'h0000);
    send_beat(lfsd_pkg::ReqLoad, 4'd3, 16'h0000, 16'h1234);
    send_beat(lfsd_pkg::ReqTask, 4'hf, 16'hffff, 16'd0);
    send_beat(lfsd_pkg::ReqTask, 4'h0, 16'h0000, 16'hffff);
    send_beat(lfsd_pkg::ReqTask, 4'h5, 16'h5555, 16'd1);
    send_beat(lfsd_pkg::ReqIdle, 4'hf, 16'hffff, 16'hffff);
    send_beat(lfsd_pkg::ReqUnused, 4'hf, 16'hffff, 16'hffff);
    send_beat(lfsd_pkg::ReqLoad, 4'd7, 16'h8000, 16'h0);
    for (int k = 0; k < 14; k++) send_beat(lfsd_pkg::ReqTask, 4'd0, 16'd0, 16'd20);
    drain();

    // hog every server and overflow the queue while the receiver stalls
    long_stall = 1'b1;
    for (int k = 0; k < 82; k++) send_beat(lfsd_pkg::ReqTask, 4'd0, 16'd0, 16'd200);
    for (int k = 0; k < 60; k++) send_beat(lfsd_pkg::ReqIdle, 4'd0, 16'd0, 16'd0);
    drain();

    for (int i = 0; i < 285; ) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst; j++) begin
        random_beat(i < 142 ? 45 : 70);
        i++;
      end
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 15));
      if (!mid_done && i > 140) begin
        drain();
        mid_done = 1'b1;
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[sim.f]
src/lfsd_pkg.sv
src/lfsd_ram.sv
src/lightest_free_server_dispatcher_top.sv
dv/lightest_free_server_dispatcher_top_test.sv
